### rtl/embedding_row_gather_macros.svh
// ----------------------------------------------------------------------------
// embedding_row_gather_macros
// Assertion macros for the embedding row gather block.
// ----------------------------------------------------------------------------
`ifndef EMBEDDING_ROW_GATHER_MACROS_SVH
`define EMBEDDING_ROW_GATHER_MACROS_SVH
`ifndef ASSERT_OFF
`define ERG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`else
`define ERG_ASSERT(label, clk, rst_n, prop)
`endif
`ifndef ASSERT_OFF
`define ERG_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ERG_NEVER(label, clk, rst_n, cond)
`endif
`endif

### rtl/erg_pkg.sv
// ----------------------------------------------------------------------------
// erg_pkg
// Types, constants and the fp16 widening function for the row gather block.
// ----------------------------------------------------------------------------
package erg_pkg;

    localparam int TABLE_ROWS_DEF    = 1024;
    localparam int MAX_ROW_WIDTH_DEF = 64;

    localparam logic [1:0] REG_VOCAB_ROWS = 2'd0;
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FORMAT     = 2'd2;

    localparam logic [1:0] FMT_FP32 = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_BF16 = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TOKEN = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [9:0]         entry_row;
        logic [5:0]         entry_column;
        logic [31:0]        entry_bits;
        logic signed [31:0] token_id;
        logic               batch_last;
    } in_word_t;

    typedef struct packed {
        logic [31:0]        element_bits;
        logic [15:0]        token_position;
        logic [5:0]         column_index;
        logic               range_error;
        logic signed [31:0] offending_id;
        logic               row_done;
        logic               batch_done;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture the token and start a row
        logic       read;      // read column and advance
        logic       emit_row;  // never set; the datapath emits row elements from its registered read
        logic       emit_err;
        logic       emit_close;
        logic       row_fin;
        logic       batch_end;
    } ctl_cmd_t;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [7:0]  e;
        logic [3:0]  lz;
        logic [10:0] sh;
        begin
            sign = {h[15], 31'd0};
            ex   = h[14:10];
            man  = h[9:0];
            lz   = 4'd0;
            for (int i = 0; i < 10; i++)
            begin
                if (man[i])
                    lz = 4'(9 - i);
            end
            if (ex == 5'd0)
            begin
                if (man == 10'd0)
                    widen_half = sign;
                else
                begin
                    sh = {1'b0, man} << (lz + 4'd1);
                    e  = 8'd113 - 8'(lz) - 8'd1;
                    widen_half = sign | {1'b0, e, sh[9:0], 13'd0};
                end
            end
            else if (ex == 5'd31)
                widen_half = sign | 32'h7F80_0000 | {9'd0, man, 13'd0};
            else
                widen_half = sign | {1'b0, 8'(ex) + 8'd112, man, 13'd0};
        end
    endfunction

endpackage

### rtl/erg_datapath.sv
// ----------------------------------------------------------------------------
// erg_datapath
// Table memory, token registers, position count and result register.
// ----------------------------------------------------------------------------
module erg_datapath #(
    parameter int TABLE_ROWS    = 1024,
    parameter int MAX_ROW_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mem_we,
    input  logic [9:0]         wr_row,
    input  logic [5:0]         wr_col,
    input  logic [31:0]        wr_data,
    input  logic signed [31:0] tok_in,
    input  logic               last_in,
    input  logic [1:0]         fmt,
    input  erg_pkg::ctl_cmd_t  cmd,
    output logic [5:0]         col,
    output logic               last_tok,
    output logic               strobe,
    output erg_pkg::out_word_t result
);
    import erg_pkg::*;

    localparam int RW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int CW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int AW = RW + CW;
    // rows are laid out on a power-of-two column pitch
    localparam int DEPTH = TABLE_ROWS << CW;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_reg;
    logic [RW-1:0] row_reg;
    logic [5:0] col_reg, rcol_reg;
    logic signed [31:0] id_reg;
    logic last_reg;
    logic [15:0] pos_reg, tpos_reg;
    logic emit_reg, fin_reg, bend_reg;
    logic strobe_reg;
    out_word_t res_reg;
    logic [31:0] wide;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[{RW'(wr_row), CW'(wr_col)}] <= wr_data;
        if (cmd.read)
            rd_reg <= mem[AW'({row_reg, col_reg[CW-1:0]})];
    end

    always_comb
    begin
        case (fmt)
            FMT_FP16: wide = widen_half(rd_reg[15:0]);
            FMT_BF16: wide = {rd_reg[15:0], 16'd0};
            default:  wide = rd_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            col_reg    <= '0;
            emit_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            row_reg    <= '0;
            id_reg     <= '0;
            last_reg   <= 1'b0;
            tpos_reg   <= '0;
            rcol_reg   <= '0;
            fin_reg    <= 1'b0;
            bend_reg   <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            emit_reg   <= cmd.read;
            if (cmd.load)
            begin
                row_reg  <= tok_in[RW-1:0];
                id_reg   <= tok_in;
                last_reg <= last_in;
                tpos_reg <= pos_reg;
                col_reg  <= '0;
                if (last_in)
                    pos_reg <= '0;
                else if (pos_reg != 16'hFFFF)
                    pos_reg <= pos_reg + 16'd1;
            end
            if (cmd.read)
            begin
                rcol_reg <= col_reg;
                fin_reg  <= cmd.row_fin;
                bend_reg <= cmd.batch_end;
                col_reg  <= col_reg + 6'd1;
            end
            if (emit_reg)
            begin
                strobe_reg <= 1'b1;
                res_reg    <= '{wide, tpos_reg, rcol_reg, 1'b0, 32'sd0, fin_reg, bend_reg};
            end
            else if (cmd.emit_err)
            begin
                strobe_reg <= 1'b1;
                res_reg    <= '{32'd0, tpos_reg, 6'd0, 1'b1, id_reg, 1'b1, last_reg};
            end
            else if (cmd.emit_close)
            begin
                strobe_reg <= 1'b1;
                res_reg    <= '{32'd0, tpos_reg, 6'd0, 1'b0, 32'sd0, 1'b1, 1'b1};
            end
        end
    end

    assign col      = col_reg;
    assign last_tok = last_reg;
    assign strobe   = strobe_reg;
    assign result   = res_reg;
endmodule

### rtl/erg_ctrl.sv
// ----------------------------------------------------------------------------
// erg_ctrl
// Sequencer: classifies each token, walks the row columns, tracks batch errors.
// ----------------------------------------------------------------------------
module erg_ctrl #(
    parameter int TABLE_ROWS    = 1024,
    parameter int MAX_ROW_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               kind,
    input  logic signed [31:0] tok_in,
    input  logic               last_in,
    input  logic [10:0]        vocab_rows,
    input  logic [6:0]         row_width,
    input  logic [5:0]         col,
    input  logic               last_tok,
    output logic               busy,
    output logic               mem_we,
    output erg_pkg::ctl_cmd_t  cmd
);
    import erg_pkg::*;
    `include "embedding_row_gather_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROW  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [16:0] ROWS = 17'(TABLE_ROWS);
    localparam logic [6:0]  MAXW = 7'(MAX_ROW_WIDTH);

    logic [1:0] state_reg, state_next;
    logic err_reg, err_next;
    logic [16:0] limit;
    logic [6:0] width;
    logic accept, bad, fin;
    ctl_cmd_t cmd_base;

    assign accept = start && !busy;
    assign limit  = ({6'd0, vocab_rows} < ROWS) ? {6'd0, vocab_rows} : ROWS;
    assign width  = (row_width == 7'd0) ? 7'd1 : ((row_width > MAXW) ? MAXW : row_width);
    assign bad    = tok_in[31] || (tok_in[30:0] >= {14'd0, limit});
    assign fin    = ({1'b0, col} + 7'd1) == width;
    assign busy   = state_reg != ST_IDLE;
    assign mem_we = accept && kind == KIND_WRITE;
    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        cmd_base       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_TOKEN)
                begin
                    cmd_base.load = 1'b1;
                    if (err_reg)
                        state_next = ST_DRAIN;
                    else if (bad)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_DRAIN;
                    end
                    else
                        state_next = ST_ROW;
                    if (last_in)
                        err_next = 1'b0;
                end
            end
            ST_ROW:
            begin
                cmd_base.read      = 1'b1;
                cmd_base.row_fin   = fin;
                cmd_base.batch_end = fin && last_tok;
                if (fin)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // error/close results go out from the drain state using latched flags
    logic kind_err_reg, kind_close_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            err_reg        <= 1'b0;
            kind_err_reg   <= 1'b0;
            kind_close_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            err_reg        <= err_next;
            kind_err_reg   <= 1'b0;
            kind_close_reg <= 1'b0;
            if (cmd_base.load)
            begin
                kind_err_reg   <= !err_reg && bad;
                kind_close_reg <= err_reg && last_in;
            end
        end
    end

    // drive error/close in the cycle after load (state DRAIN, first cycle)
    logic drain_first;
    assign drain_first = (state_reg == ST_DRAIN);

    always_comb
    begin
        cmd            = cmd_base;
        cmd.emit_err   = drain_first && kind_err_reg;
        cmd.emit_close = drain_first && kind_close_reg;
    end

    `ERG_NEVER(a_no_read_idle, clk, rst_n, cmd.read && state_reg == ST_IDLE)
    `ERG_NEVER(a_err_close_excl, clk, rst_n, kind_err_reg && kind_close_reg)
    `ERG_ASSERT(a_fin_drains, clk, rst_n,
        (state_reg == ST_ROW && fin) |=> state_reg == ST_DRAIN)
endmodule

### rtl/embedding_row_gather.sv
// Embedding row gather: a table write is taken while idle; a token id loads, then
// reads the memory once per column and drains, an error or closing id loads and drains.
// A row element goes through the memory read and emit registers before its strobe, an
// error or closing result is strobed from the drain state; results cannot be stalled.
// Async active-low reset clears control, position count and error flag;
// registers reset to 1024 rows, 64 columns, fp32. Table contents start undefined.
// ----------------------------------------------------------------------------
// embedding_row_gather
// Top level: config registers, sequencer and datapath.
// ----------------------------------------------------------------------------
module embedding_row_gather #(
    parameter int TABLE_ROWS    = erg_pkg::TABLE_ROWS_DEF,
    parameter int MAX_ROW_WIDTH = erg_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  erg_pkg::in_word_t  in_word,
    output logic               strobe,
    output erg_pkg::out_word_t result,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data
);
    import erg_pkg::*;

    logic [10:0] vocab_reg;
    logic [6:0]  width_reg;
    logic [1:0]  fmt_reg;
    ctl_cmd_t    cmd;
    logic [5:0]  col;
    logic        last_tok, mem_we, wr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vocab_reg <= 11'd1024;
            width_reg <= 7'd64;
            fmt_reg   <= FMT_FP32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VOCAB_ROWS: vocab_reg <= cfg_data;
                REG_ROW_WIDTH:  width_reg <= cfg_data[6:0];
                REG_FORMAT:     fmt_reg   <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    assign wr_ok = mem_we && (32'(in_word.entry_row) < 32'(TABLE_ROWS))
                   && (32'(in_word.entry_column) < 32'(MAX_ROW_WIDTH));

    erg_ctrl #(.TABLE_ROWS(TABLE_ROWS), .MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(in_word.kind),
        .tok_in(in_word.token_id), .last_in(in_word.batch_last),
        .vocab_rows(vocab_reg), .row_width(width_reg), .col(col),
        .last_tok(last_tok), .busy(busy), .mem_we(mem_we), .cmd(cmd)
    );

    erg_datapath #(.TABLE_ROWS(TABLE_ROWS), .MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .mem_we(wr_ok), .wr_row(in_word.entry_row),
        .wr_col(in_word.entry_column), .wr_data(in_word.entry_bits),
        .tok_in(in_word.token_id), .last_in(in_word.batch_last), .fmt(fmt_reg),
        .cmd(cmd), .col(col), .last_tok(last_tok), .strobe(strobe), .result(result)
    );
endmodule

### tb/embedding_row_gather_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// embedding_row_gather_tb
// Loads the table, then sends directed and random token batches under several
// register settings; a scoreboard predicts each result word and checks it.
// ----------------------------------------------------------------------------
import erg_pkg::*;

class gather_scoreboard;
    logic [31:0] table_mem [0:65535];
    int unsigned vocab_rows;
    int unsigned row_width;
    logic [1:0]  fmt;
    logic [15:0] position;
    bit          err_seen;
    out_word_t   pending [$];
    int          fails;

    function new();
        vocab_rows = 1024;
        row_width  = 64;
        fmt        = FMT_FP32;
        position   = 16'd0;
        err_seen   = 1'b0;
        fails      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [10:0] data);
        case (idx)
            REG_VOCAB_ROWS: vocab_rows = data;
            REG_ROW_WIDTH:  row_width  = data[6:0];
            REG_FORMAT:     fmt        = data[1:0];
            default: ;
        endcase
    endfunction

    function logic [31:0] half_to_single(logic [15:0] h);
        logic [31:0] sgn;
        logic [10:0] man;
        logic [7:0]  e;
        sgn = {h[15], 31'd0};
        man = {1'b0, h[9:0]};
        if (h[14:10] == 5'd0)
        begin
            if (man == 11'd0)
                return sgn;
            e = 8'd113;
            while (!man[10])
            begin
                man = man << 1;
                e   = e - 8'd1;
            end
            return sgn | {1'b0, e, man[9:0], 13'd0};
        end
        if (h[14:10] == 5'd31)
            return sgn | 32'h7F80_0000 | {9'd0, man[9:0], 13'd0};
        return sgn | {1'b0, 8'(h[14:10]) + 8'd112, man[9:0], 13'd0};
    endfunction

    function logic [31:0] widen(logic [31:0] raw);
        case (fmt)
            FMT_FP16: return half_to_single(raw[15:0]);
            FMT_BF16: return {raw[15:0], 16'd0};
            default:  return raw;
        endcase
    endfunction

    function void add(logic [31:0] el, int col, logic err, logic [31:0] bad,
                      logic rd, logic bd);
        out_word_t o;
        o.element_bits   = el;
        o.token_position = position;
        o.column_index   = 6'(col);
        o.range_error    = err;
        o.offending_id   = bad;
        o.row_done       = rd;
        o.batch_done     = bd;
        pending.push_back(o);
    endfunction

    // called for every accepted input word
    function void note(in_word_t w);
        int lim;
        int wd;
        if (w.kind == KIND_WRITE)
        begin
            table_mem[{w.entry_row, w.entry_column}] = w.entry_bits;
            return;
        end
        lim = (vocab_rows > 1024) ? 1024 : vocab_rows;
        wd  = (row_width == 0) ? 1 : ((row_width > 64) ? 64 : row_width);
        if (err_seen)
        begin
            if (w.batch_last)
                add(32'd0, 0, 1'b0, 32'd0, 1'b1, 1'b1);
        end
        else if (w.token_id < 0 || w.token_id >= lim)
        begin
            add(32'd0, 0, 1'b1, w.token_id, 1'b1, w.batch_last);
            err_seen = 1'b1;
        end
        else
        begin
            for (int c = 0; c < wd; c++)
                add(widen(table_mem[{w.token_id[9:0], 6'(c)}]), c, 1'b0, 32'd0,
                    c == wd - 1, (c == wd - 1) && w.batch_last);
        end
        if (w.batch_last)
        begin
            position = 16'd0;
            err_seen = 1'b0;
        end
        else if (position != 16'hFFFF)
            position++;
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
            fails++;
        end
    endfunction

    function void check(out_word_t r);
        out_word_t e;
        if (pending.size() == 0)
        begin
            $display("%0t unexpected result word %h", $time, r);
            fails++;
            return;
        end
        e = pending.pop_front();
        cmp("element_bits", e.element_bits, r.element_bits);
        cmp("token_position", e.token_position, r.token_position);
        cmp("column_index", e.column_index, r.column_index);
        cmp("range_error", e.range_error, r.range_error);
        cmp("offending_id", e.offending_id, r.offending_id);
        cmp("row_done", e.row_done, r.row_done);
        cmp("batch_done", e.batch_done, r.batch_done);
    endfunction
endclass

module embedding_row_gather_tb;
    localparam int IDLE_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_word_t    in_word;
    logic        strobe;
    out_word_t   result;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;

    gather_scoreboard sb;
    bit   burst;
    int   idle_cycles;

    embedding_row_gather u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_word   (in_word),
        .strobe    (strobe),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || cfg_we || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send(in_word_t w);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (busy);
        sb.note(w);
    endtask

    task automatic write_entry(int row, int col, logic [31:0] bits);
        in_word_t w;
        w = '0;
        w.kind         = KIND_WRITE;
        w.entry_row    = 10'(row);
        w.entry_column = 6'(col);
        w.entry_bits   = bits;
        w.token_id     = $urandom;
        w.batch_last   = $urandom_range(0, 1);
        send(w);
    endtask

    task automatic token(logic [31:0] id, logic last);
        in_word_t w;
        w = '0;
        w.kind         = KIND_TOKEN;
        w.entry_row    = $urandom;
        w.entry_column = $urandom;
        w.entry_bits   = $urandom;
        w.token_id     = id;
        w.batch_last   = last;
        send(w);
    endtask

    // drain, then write registers while the block is idle
    task automatic set_regs(int vocab, int width, int fmt_code);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= REG_VOCAB_ROWS; cfg_data <= 11'(vocab);
        @(posedge clk);
        sb.set_reg(REG_VOCAB_ROWS, 11'(vocab));
        cfg_index <= REG_ROW_WIDTH; cfg_data <= 11'(width);
        @(posedge clk);
        sb.set_reg(REG_ROW_WIDTH, 11'(width));
        cfg_index <= REG_FORMAT; cfg_data <= 11'(fmt_code);
        @(posedge clk);
        sb.set_reg(REG_FORMAT, 11'(fmt_code));
        cfg_we <= 1'b0;
    endtask

    // good ids come only from the loaded rows 0..2 and 1023
    task automatic random_items(int count);
        int lim;
        int row;
        for (int i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
                burst = ($urandom_range(0, 2) == 0);
            lim = (sb.vocab_rows > 1024) ? 1024 : sb.vocab_rows;
            if ($urandom_range(0, 9) == 0)
                write_entry($urandom_range(0, 1023), $urandom_range(0, 63), $urandom);
            else if ($urandom_range(0, 3) != 0 && lim > 0)
            begin
                row = $urandom_range(0, 3);
                if (row == 3)
                    row = 1023;
                if (row >= lim)
                    row = $urandom_range(0, (lim > 3 ? 3 : lim) - 1);
                token(row, $urandom_range(0, 4) == 0);
            end
            else if ($urandom_range(0, 1) == 0)
                token(32'h8000_0000 | $urandom, $urandom_range(0, 4) == 0);
            else
                token($urandom_range(lim, 32'h7FFF_FFFF), $urandom_range(0, 4) == 0);
        end
        token(0, 1'b1);
    endtask

    initial
    begin
        logic [15:0] specials [0:8];
        specials = '{16'h0000, 16'h8000, 16'h0001, 16'h83FF, 16'h7C00,
                     16'hFC00, 16'h7E01, 16'h3C00, 16'h7BFF};
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        in_word     = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_VOCAB_ROWS;
        cfg_data    = '0;
        burst       = 1'b0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // table load: rows 0..2 and the top row, every column
        burst = 1'b1;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 64; c++)
                write_entry(r == 3 ? 1023 : r, c, $urandom);
        end
        for (int c = 0; c < 9; c++)
            write_entry(2, c, {16'($urandom), specials[c]});
        burst = 1'b0;

        // directed: extremes, bad ids, errors mid batch and at batch end
        token(0, 1'b0);
        token(1023, 1'b0);
        token(32'hFFFF_FFFF, 1'b0);
        token(1, 1'b0);
        token(1024, 1'b1);
        token(32'h8000_0000, 1'b1);
        token(32'h7FFF_FFFF, 1'b0);
        token(2, 1'b1);
        token(1, 1'b1);
        set_regs(32, 9, FMT_FP16);
        token(2, 1'b0);
        token(32, 1'b0);
        token(33, 1'b1);
        set_regs(1, 1, FMT_BF16);
        token(0, 1'b0);
        token(1, 1'b1);
        set_regs(0, 0, 3);
        token(0, 1'b1);
        set_regs(2047, 127, FMT_FP16);
        token(2, 1'b0);
        token(1023, 1'b1);

        random_items(10);
        set_regs(1024, 64, FMT_FP32);
        random_items(10);
        set_regs(1, 1, FMT_BF16);
        random_items(10);
        set_regs(500, 0, 3);
        random_items(10);
        set_regs(32, 17, FMT_FP16);
        random_items(10);
        set_regs(2047, 127, FMT_BF16);
        random_items(10);
        set_regs($urandom_range(1, 1024), $urandom_range(1, 64), FMT_FP16);
        random_items(10);
        set_regs(0, 64, FMT_FP32);
        random_items(5);

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (70) @(posedge clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
